// ===== design/siph_pkg.sv =====
// Shared types, constants and the SipRound function for the keyed hash block.
// No dependencies; every design module imports this package.
package siph_pkg;

   localparam logic [63:0] C_LANE_A  = 64'h736f6d6570736575;
   localparam logic [63:0] C_LANE_B  = 64'h646f72616e646f6d;
   localparam logic [63:0] C_LANE_C  = 64'h6c7967656e657261;
   localparam logic [63:0] C_LANE_D  = 64'h7465646279746573;
   localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;
   localparam int          LEN_SHIFT = 56;

   localparam logic [1:0] REG_KEY_LOW   = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH  = 2'd1;
   localparam logic [1:0] REG_HALF_MODE = 2'd2;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
   } lanes_type;

   typedef struct packed {
      logic [63:0] key_low;
      logic [63:0] key_high;
      logic        half;
   } cfg_type;

   // One block for the back end: a word to absorb, whether it opens a
   // message, and whether finalization follows it.
   typedef struct packed {
      logic [63:0] msg;
      logic        start;
      logic        is_final;
   } entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROUND,
      BK_FINAL,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      back_state_type state;
      logic           out_free;
   } back_status_type;

   function automatic lanes_type sip_round(lanes_type s);
      lanes_type t;
      t   = s;
      t.a = t.a + t.b;
      t.b = {t.b[50:0], t.b[63:51]} ^ t.a;
      t.a = {t.a[31:0], t.a[63:32]};
      t.c = t.c + t.d;
      t.d = {t.d[47:0], t.d[63:48]} ^ t.c;
      t.a = t.a + t.d;
      t.d = {t.d[42:0], t.d[63:43]} ^ t.a;
      t.c = t.c + t.b;
      t.b = {t.b[46:0], t.b[63:47]} ^ t.c;
      t.c = {t.c[31:0], t.c[63:32]};
      return t;
   endfunction

endpackage

// ===== design/siph_req_if.sv =====
// Input channel of the keyed hash block: one message word per transfer.
// Depends on nothing.
interface siph_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  word_bytes;
   logic        last;

   modport source (output valid, output data_word, output word_bytes, output last,
                   input ready);
   modport sink   (input valid, input data_word, input word_bytes, input last,
                   output ready);
endinterface

// ===== design/siph_rsp_if.sv =====
// Result channel of the keyed hash block: one hash per transfer.
// Depends on nothing.
interface siph_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

// ===== design/siph_csr_if.sv =====
// Register write channel of the keyed hash block: index and data per transfer.
// Depends on nothing.
interface siph_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/siph_front.sv =====
// Front end: accepts message words, tracks length, builds absorb blocks.
// Depends on siph_pkg and siph_req_if.
module siph_front
   import siph_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   siph_req_if.sink   req,
   input  logic       q_ready,
   output logic       q_push,
   output entry_type  q_entry
);

   logic       in_msg_ff, in_msg_in;
   logic [7:0] total_ff, total_in;
   logic       pend_ff, pend_in;
   logic [7:0] pend_len_ff, pend_len_in;

   logic       accept;
   logic       full_last;
   logic [3:0] nbytes;
   logic [7:0] tail_len;
   logic [63:0] masked;

   assign req.ready = q_ready && !pend_ff;
   assign accept    = req.valid && req.ready;
   assign full_last = req.last && req.word_bytes[3];
   assign nbytes    = req.word_bytes[3] ? 4'd8 : req.word_bytes;
   assign tail_len  = total_ff + {4'd0, nbytes};

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked[8*i +: 8] = (4'(i) < nbytes) ? req.data_word[8*i +: 8] : 8'd0;
      end
   end

   always_comb begin
      in_msg_in   = in_msg_ff;
      total_in    = total_ff;
      pend_in     = pend_ff;
      pend_len_in = pend_len_ff;
      q_push      = 1'b0;
      q_entry     = '{msg: req.data_word, start: !in_msg_ff, is_final: 1'b0};
      if (pend_ff) begin
         // Length-only block that follows a full last word; hold it until
         // the queue has room.
         q_entry = '{msg: {pend_len_ff, 56'd0}, start: 1'b0, is_final: 1'b1};
         if (q_ready) begin
            q_push  = 1'b1;
            pend_in = 1'b0;
         end
      end else if (accept) begin
         q_push = 1'b1;
         if (!req.last) begin
            in_msg_in = 1'b1;
            total_in  = total_ff + 8'd8;
         end else begin
            in_msg_in = 1'b0;
            total_in  = 8'd0;
            if (full_last) begin
               pend_in     = 1'b1;
               pend_len_in = tail_len;
            end else begin
               q_entry.msg      = masked | ({56'd0, tail_len} << LEN_SHIFT);
               q_entry.is_final = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         total_ff  <= 8'd0;
         pend_ff   <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
         total_ff  <= total_in;
         pend_ff   <= pend_in;
      end
      pend_len_ff <= pend_len_in;
   end

endmodule

// ===== design/siph_queue.sv =====
// Two-entry queue of absorb blocks between front and back end.
// Depends on siph_pkg.
module siph_queue
   import siph_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      push_ready,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      pop_valid
);

   entry_type  mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_entry  = mem_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/siph_back.sv =====
// Back end: runs SipRounds on queued blocks, finalizes, holds the result.
// Depends on siph_pkg and siph_rsp_if.
module siph_back
   import siph_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  entry_type       q_entry,
   input  logic            q_valid,
   output logic            q_pop,
   siph_rsp_if.source      rsp,
   output back_status_type status
);

   back_state_type state_ff, state_in;
   lanes_type      lanes_ff, lanes_in;
   logic [63:0]    m_ff, m_in;
   logic           fin_ff, fin_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    hash_ff, hash_in;

   lanes_type   init, base, src, rnd, post;
   logic [63:0] k0, k1, msg_sel, hash_all;
   logic        fin_sel, xor_on, out_free;
   logic [1:0]  last_cnt;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign last_cnt = cfg.half ? 2'd2 : 2'd3;
   assign k0       = cfg.half ? {32'd0, cfg.key_low[31:0]} : cfg.key_low;
   assign k1       = cfg.half ? 64'd0 : cfg.key_high;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (!cfg.half) begin
                  state_in = BK_ROUND;
               end else if (q_entry.is_final) begin
                  state_in = BK_FINAL;
               end
            end
         end
         BK_ROUND: state_in = fin_ff ? BK_FINAL : BK_IDLE;
         BK_FINAL: begin
            if (cnt_ff == last_cnt) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      init = '{a: C_LANE_A ^ k0, b: C_LANE_B ^ k1, c: C_LANE_C ^ k0, d: C_LANE_D ^ k1};
      base   = q_entry.start ? init : lanes_ff;
      base.d = base.d ^ q_entry.msg;
      src    = (state_ff == BK_IDLE) ? base : lanes_ff;
      rnd    = sip_round(src);

      msg_sel = (state_ff == BK_IDLE) ? q_entry.msg : m_ff;
      fin_sel = (state_ff == BK_IDLE) ? q_entry.is_final : fin_ff;
      xor_on  = ((state_ff == BK_IDLE) && cfg.half) || (state_ff == BK_ROUND);
      post    = rnd;
      if (xor_on) begin
         post.a = post.a ^ msg_sel;
         if (fin_sel) begin
            post.c = post.c ^ FINAL_XOR;
         end
      end

      hash_all = lanes_ff.a ^ lanes_ff.b ^ lanes_ff.c ^ lanes_ff.d;

      lanes_in     = lanes_ff;
      m_in         = m_ff;
      fin_in       = fin_ff;
      cnt_in       = 2'd0;
      q_pop        = 1'b0;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               lanes_in = post;
               m_in     = q_entry.msg;
               fin_in   = q_entry.is_final;
            end
         end
         BK_ROUND: lanes_in = post;
         BK_FINAL: begin
            lanes_in = rnd;
            cnt_in   = cnt_ff + 2'd1;
         end
         BK_EMIT: begin
            if (out_free) begin
               hash_in      = cfg.half ? {32'd0, hash_all[31:0]} : hash_all;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hash_value  = hash_ff;
   assign status.state    = state_ff;
   assign status.out_free = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lanes_ff <= lanes_in;
      m_ff     <= m_in;
      fin_ff   <= fin_in;
      hash_ff  <= hash_in;
   end

endmodule

// ===== design/siphash_keyed_hash.sv =====
// Top level of the keyed SipHash block: registers, front, queue, back end.
// Depends on siph_pkg, the three channel interfaces and all siph_ modules.
//
//   channel    role     payload                          transfer means
//   req_port   sink     data_word, word_bytes, last      one message word
//   rsp_port   source   hash_value                       one finished hash
//   csr_port   sink     index, data                      one register write
//
// One SipRound per clock while the back end absorbs or finalizes. A word that
// is not last takes two rounds (full) or one (half); a last item takes its
// absorb rounds, then 4 (full) or 3 (half) finalization rounds, then emit
// loads the result register; a last item of eight bytes adds one absorb for
// the length block. Reset is synchronous and clears control state only.
// A stalled result holds in its register while the next message is absorbed.
module siphash_keyed_hash
   import siph_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   siph_req_if.sink   req_port,
   siph_rsp_if.source rsp_port,
   siph_csr_if.sink   csr_port
);

   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] key_high_ff, key_high_in;
   logic        half_ff, half_in;

   cfg_type         cfg;
   entry_type       push_entry, pop_entry;
   logic            q_push, q_ready, q_pop, q_valid;
   back_status_type back_status;

   // Register writes are always taken; an index beyond the list is dropped.
   assign csr_port.ready = 1'b1;

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      half_in     = half_ff;
      if (csr_port.valid) begin
         case (csr_port.index)
            REG_KEY_LOW:   key_low_in  = csr_port.data;
            REG_KEY_HIGH:  key_high_in = csr_port.data;
            REG_HALF_MODE: half_in     = csr_port.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= 64'd0;
         key_high_ff <= 64'd0;
         half_ff     <= 1'b0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         half_ff     <= half_in;
      end
   end

   assign cfg = '{key_low: key_low_ff, key_high: key_high_ff, half: half_ff};

   // Front end: count bytes, mask the tail, split a full last word in two.
   siph_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_port),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   // Decouple word intake from the round engine.
   siph_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .pop_valid  (q_valid)
   );

   // Round engine and result register.
   siph_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_entry (pop_entry),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp     (rsp_port),
      .status  (back_status)
   );

   // The front end never offers a block the queue cannot hold.
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_ready)
      else $error("front pushed into a full queue");

   // A new result appears only out of the emit step.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_port.valid) |-> $past(back_status.state == BK_EMIT))
      else $error("result raised outside the emit step");

   // Emit with a free result register always produces a result.
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (back_status.state == BK_EMIT) && back_status.out_free |=> rsp_port.valid)
      else $error("emit step did not load the result");

endmodule
